### hw/rtl/lppw_pkg.sv
// Shared constants for the line pixel packed writer.
`timescale 1ns / 1ps

package lppw_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_ADDR_BITS  = 24;

  // Fixed field widths
  localparam int IDX_W    = 12;
  localparam int COLOUR_W = 8;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int DEPTH_W  = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH   = 3'd3;

  // Register reset values
  localparam logic [CFG_W-1:0]   RST_SCREEN_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0]   RST_SCREEN_HEIGHT = 12'd480;
  localparam logic [CFG_W-1:0]   RST_LINE_PITCH    = 12'd640;
  localparam logic [DEPTH_W-1:0] RST_PIXEL_DEPTH   = 2'd0;

  // Packing codes
  localparam logic [DEPTH_W-1:0] DEPTH_8BPP = 2'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_4BPP = 2'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_2BPP = 2'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_1BPP = 2'd3;

  // Pixel masks per packing
  localparam logic [COLOUR_W-1:0] MASK_8BPP    = 8'hFF;
  localparam logic [COLOUR_W-1:0] MASK_4BPP    = 8'h0F;
  localparam logic [COLOUR_W-1:0] MASK_4BPP_HI = 8'hF0;
  localparam logic [COLOUR_W-1:0] MASK_2BPP    = 8'h03;
  localparam logic [COLOUR_W-1:0] MASK_1BPP    = 8'h01;

endpackage

### hw/rtl/lppw_udiv.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module lppw_udiv #(
  parameter int N = 12
) (
  input  logic           clk,
  input  logic [2*N-1:0] dividend,
  input  logic [N-1:0]   divisor,
  output logic [N-1:0]   quotient
);

  // Work word: partial remainder in the high half, dividend bits then
  // quotient bits in the low half. Needs dividend < divisor * 2^N.
  logic [2*N-1:0] w_r [N];
  logic [N-1:0]   d_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [2*N-1:0] w_in;
    logic [N-1:0]   d_in;
    logic [N:0]     t;
    logic [N:0]     diff;
    logic [2*N-1:0] w_nxt;

    if (i == 0) begin : g_first
      assign w_in = dividend;
      assign d_in = divisor;
    end else begin : g_next
      assign w_in = w_r[i-1];
      assign d_in = d_r[i-1];
    end

    always_comb begin
      t    = w_in[2*N-1:N-1];
      diff = t - {1'b0, d_in};
      if (t >= {1'b0, d_in}) begin
        w_nxt = {diff[N-1:0], w_in[N-2:0], 1'b1};
      end else begin
        w_nxt = {t[N-1:0], w_in[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      w_r[i] <= w_nxt;
      d_r[i] <= d_in;
    end
  end

  assign quotient = w_r[N-1][N-1:0];

endmodule

### hw/rtl/line_pixel_packed_writer.sv
// Top level: line point to masked frame-buffer byte write, fully pipelined.
`timescale 1ns / 1ps

// Takes one step of a line (endpoints, colour, step index) per clock and
// returns one masked byte write per step. busy stays low: every cycle
// accepts a transfer. The rate is set by a pipelined restoring divider, one
// quotient bit per stage, for each of x and y; three multipliers (x and y
// step scaling in stage 1, y times pitch in stage 3) sit in the pipeline.
// Each result shows on the out_ ports for one cycle with out_valid high and
// must be taken then. Configuration must be written by the user only with
// the pipeline empty; the block itself does not enforce it.
module line_pixel_packed_writer
  import lppw_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  input  logic [COLOUR_W-1:0]   in_colour,
  input  logic [IDX_W-1:0]      in_step_index,

  output logic                  out_valid,
  output logic                  out_write_enable,
  output logic [ADDR_BITS-1:0]  out_byte_offset,
  output logic [COLOUR_W-1:0]   out_bit_select,
  output logic [COLOUR_W-1:0]   out_bit_data,
  output logic                  out_last_step,
  output logic [COORD_BITS-1:0] out_line_length,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = 2 * COORD_BITS;
  localparam int PW   = COORD_BITS + IDX_W;
  localparam int CMPW = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
  localparam int YPW  = COORD_BITS + CFG_W;
  localparam int SW   = YPW + 1;

  typedef struct packed {
    logic [CW-1:0]       xs;
    logic [CW-1:0]       ys;
    logic                sx;
    logic                sy;
    logic [COLOUR_W-1:0] colour;
    logic                draw;
    logic                last;
    logic [CW-1:0]       len;
  } sband_t;

  assign busy = 1'b0;

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0]   scr_w_r;
  logic [CFG_W-1:0]   scr_h_r;
  logic [CFG_W-1:0]   pitch_r;
  logic [DEPTH_W-1:0] depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= RST_SCREEN_WIDTH;
      scr_h_r <= RST_SCREEN_HEIGHT;
      pitch_r <= RST_LINE_PITCH;
      depth_r <= RST_PIXEL_DEPTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
        CFG_LINE_PITCH:    pitch_r <= cfg_wdata;
        CFG_PIXEL_DEPTH:   depth_r <= cfg_wdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: deltas and magnitudes ----------------
  logic                in_xfer;
  logic [CW:0]         dx_nxt, dy_nxt;
  logic                s0_vld_r;
  logic [CW-1:0]       s0_xs_r, s0_ys_r, s0_adx_r, s0_ady_r;
  logic                s0_sx_r, s0_sy_r;
  logic [COLOUR_W-1:0] s0_colour_r;
  logic [IDX_W-1:0]    s0_idx_r;

  assign in_xfer = start && !busy;
  assign dx_nxt  = {1'b0, in_x_end} - {1'b0, in_x_start};
  assign dy_nxt  = {1'b0, in_y_end} - {1'b0, in_y_start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    s0_xs_r     <= in_x_start;
    s0_ys_r     <= in_y_start;
    s0_sx_r     <= dx_nxt[CW];
    s0_sy_r     <= dy_nxt[CW];
    s0_adx_r    <= dx_nxt[CW] ? CW'(~dx_nxt + 1'b1) : dx_nxt[CW-1:0];
    s0_ady_r    <= dy_nxt[CW] ? CW'(~dy_nxt + 1'b1) : dy_nxt[CW-1:0];
    s0_colour_r <= in_colour;
    s0_idx_r    <= in_step_index;
  end

  // ---------------- stage 1: length and step scaling ----------------
  logic [CW-1:0] len_nxt;
  logic [PW-1:0] xprod_nxt, yprod_nxt;
  logic          s1_vld_r;
  logic [DW-1:0] s1_xdvd_r, s1_ydvd_r;
  sband_t        s1_sb_r;

  assign len_nxt   = (s0_adx_r > s0_ady_r) ? s0_adx_r : s0_ady_r;
  assign xprod_nxt = PW'(s0_adx_r) * PW'(s0_idx_r);
  assign yprod_nxt = PW'(s0_ady_r) * PW'(s0_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  // products beyond 2*CW bits only occur on steps that are not drawn
  always_ff @(posedge clk) begin
    s1_xdvd_r      <= DW'(xprod_nxt);
    s1_ydvd_r      <= DW'(yprod_nxt);
    s1_sb_r.xs     <= s0_xs_r;
    s1_sb_r.ys     <= s0_ys_r;
    s1_sb_r.sx     <= s0_sx_r;
    s1_sb_r.sy     <= s0_sy_r;
    s1_sb_r.colour <= s0_colour_r;
    s1_sb_r.draw   <= CMPW'(s0_idx_r) < CMPW'(len_nxt);
    s1_sb_r.last   <= (len_nxt == '0) ||
                      ((CMPW + 1)'(s0_idx_r) + 1'b1 == (CMPW + 1)'(len_nxt));
    s1_sb_r.len    <= len_nxt;
  end

  // ---------------- divider stages ----------------
  logic [CW-1:0] qx, qy;
  logic [CW-1:0] dv_vld_r;
  sband_t        dv_sb_r [CW];

  lppw_udiv #(.N(CW)) u_div_x (
    .clk      (clk),
    .dividend (s1_xdvd_r),
    .divisor  (s1_sb_r.len),
    .quotient (qx)
  );

  lppw_udiv #(.N(CW)) u_div_y (
    .clk      (clk),
    .dividend (s1_ydvd_r),
    .divisor  (s1_sb_r.len),
    .quotient (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else begin
      dv_vld_r <= {dv_vld_r[CW-2:0], s1_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    dv_sb_r[0] <= s1_sb_r;
    for (int i = 1; i < CW; i++) begin
      dv_sb_r[i] <= dv_sb_r[i-1];
    end
  end

  // ---------------- stage 2: point and clipping ----------------
  sband_t              dv_out;
  logic [CW-1:0]       x_nxt, y_nxt;
  logic                s2_vld_r, s2_we_r, s2_last_r;
  logic [CW-1:0]       s2_x_r, s2_y_r, s2_len_r;
  logic [COLOUR_W-1:0] s2_colour_r;

  assign dv_out = dv_sb_r[CW-1];
  // quotient of magnitudes equals the truncated signed quotient in magnitude
  assign x_nxt  = dv_out.sx ? (dv_out.xs - qx) : (dv_out.xs + qx);
  assign y_nxt  = dv_out.sy ? (dv_out.ys - qy) : (dv_out.ys + qy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= dv_vld_r[CW-1];
    end
  end

  always_ff @(posedge clk) begin
    s2_x_r      <= x_nxt;
    s2_y_r      <= y_nxt;
    s2_we_r     <= dv_out.draw &&
                   (CMPW'(x_nxt) < CMPW'(scr_w_r)) &&
                   (CMPW'(y_nxt) < CMPW'(scr_h_r));
    s2_colour_r <= dv_out.colour;
    s2_last_r   <= dv_out.last;
    s2_len_r    <= dv_out.len;
  end

  // ---------------- stage 3: row offset and bit lanes ----------------
  logic [COLOUR_W-1:0] sel_nxt, dat_nxt;
  logic [2:0]          sh_nxt;
  logic                s3_vld_r, s3_we_r, s3_last_r;
  logic [YPW-1:0]      s3_row_r;
  logic [CW-1:0]       s3_xb_r, s3_len_r;
  logic [COLOUR_W-1:0] s3_sel_r, s3_dat_r;

  always_comb begin
    sh_nxt  = '0;
    sel_nxt = MASK_8BPP;
    dat_nxt = s2_colour_r;
    case (depth_r)
      DEPTH_8BPP: begin
        sel_nxt = MASK_8BPP;
        dat_nxt = s2_colour_r;
      end
      DEPTH_4BPP: begin
        sel_nxt = s2_x_r[0] ? MASK_4BPP_HI : MASK_4BPP;
        dat_nxt = s2_x_r[0] ? {s2_colour_r[3:0], 4'h0} : (s2_colour_r & MASK_4BPP);
      end
      DEPTH_2BPP: begin
        sh_nxt  = {s2_x_r[1:0], 1'b0};
        sel_nxt = MASK_2BPP << sh_nxt;
        dat_nxt = (s2_colour_r & MASK_2BPP) << sh_nxt;
      end
      DEPTH_1BPP: begin
        sh_nxt  = s2_x_r[2:0];
        sel_nxt = MASK_1BPP << sh_nxt;
        dat_nxt = (s2_colour_r & MASK_1BPP) << sh_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_row_r  <= YPW'(s2_y_r) * YPW'(pitch_r);
    s3_xb_r   <= s2_x_r >> depth_r;
    s3_sel_r  <= sel_nxt;
    s3_dat_r  <= dat_nxt;
    s3_we_r   <= s2_we_r;
    s3_last_r <= s2_last_r;
    s3_len_r  <= s2_len_r;
  end

  // ---------------- stage 4: output register ----------------
  logic [SW-1:0]        off_sum;
  logic                 out_valid_r, out_we_r, out_last_r;
  logic [ADDR_BITS-1:0] out_off_r;
  logic [COLOUR_W-1:0]  out_sel_r, out_dat_r;
  logic [CW-1:0]        out_len_r;

  assign off_sum = SW'(s3_row_r) + SW'(s3_xb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_we_r   <= s3_we_r;
    out_off_r  <= s3_we_r ? ADDR_BITS'(off_sum) : '0;
    out_sel_r  <= s3_we_r ? s3_sel_r : '0;
    out_dat_r  <= s3_we_r ? s3_dat_r : '0;
    out_last_r <= s3_last_r;
    out_len_r  <= s3_len_r;
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_byte_offset  = out_off_r;
  assign out_bit_select   = out_sel_r;
  assign out_bit_data     = out_dat_r;
  assign out_last_step    = out_last_r;
  assign out_line_length  = out_len_r;

endmodule
